FILE: hw/rtl/rcsfd_pkg.sv
// ----------------------------------------------------------------------------
// rcsfd_pkg: shared definitions for the serial frame decoder
// Frame geometry, decode constants, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rcsfd_pkg;

  // Frame geometry
  localparam int FRAME_LEN     = 21;
  localparam int POS_W         = 5;
  localparam int CHANNEL_COUNT = 8;
  localparam int CH_IDX_W      = 3;

  // Fixed byte positions inside the frame
  localparam logic [POS_W-1:0] HDR_POS  = 5'd0;
  localparam logic [POS_W-1:0] TAIL_POS = 5'd19;
  localparam logic [POS_W-1:0] LAST_POS = 5'd20;
  localparam logic [POS_W-1:0] HI_BASE  = 5'd3;
  localparam logic [POS_W-1:0] LO_BASE  = 5'd4;
  localparam logic [POS_W-1:0] NXT_BASE = 5'd5;

  // Decode constants
  localparam logic [7:0]  HEADER_BYTE = 8'hA8;
  localparam logic [15:0] OFFSET_SUB  = 16'd375;

  // Configuration register map
  localparam int          CFG_IDX_W     = 8;
  localparam int          CFG_DATA_W    = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_VALUE = 8'd1;
  localparam logic [15:0] GAP_LIMIT_RST = 16'd5000;
  localparam logic [15:0] MID_VALUE_RST = 16'd1500;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BYTE,
    ST_CHECK,
    ST_HDR,
    ST_TAIL,
    ST_HI,
    ST_LO,
    ST_PICK,
    ST_FINISH
  } state_t;

  // Frame buffer read address select
  typedef enum logic [2:0] {
    SEL_HDR,
    SEL_TAIL,
    SEL_HI,
    SEL_LO,
    SEL_NEXT_HI
  } rd_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load_item;
    logic    byte_write;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    chk_hdr;
    logic    chk_tail;
    logic    dec_hi;
    logic    dec_lo;
    logic    pick;
    logic    push;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic complete;
    logic frame_ok;
    logic k_last;
    logic out_free;
  } sts_t;

  // Logical to physical channel remap
  function automatic logic [CH_IDX_W-1:0] chan_map(input logic [CH_IDX_W-1:0] ch);
    logic [CH_IDX_W-1:0] m;
    case (ch)
      3'd0:    m = 3'd1;
      3'd1:    m = 3'd2;
      3'd2:    m = 3'd3;
      3'd3:    m = 3'd0;
      3'd4:    m = 3'd4;
      3'd5:    m = 3'd5;
      3'd6:    m = 3'd6;
      3'd7:    m = 3'd7;
      default: m = 3'd0;
    endcase
    return m;
  endfunction

endpackage

FILE: hw/rtl/rcsfd_if.sv
// ----------------------------------------------------------------------------
// rcsfd_if: request and result channels of the serial frame decoder
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rcsfd_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  rx_byte;
  logic [31:0] arrival_time_us;
  logic [7:0]  channel;

  modport source (output valid, op, rx_byte, arrival_time_us, channel, input ready);
  modport sink   (input valid, op, rx_byte, arrival_time_us, channel, output ready);
endinterface

interface rcsfd_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] channel_value;
  logic        frame_pending;
  logic        failsafe_clear;
  logic        frame_loaded;

  modport source (output valid, channel_value, frame_pending, failsafe_clear,
                  frame_loaded, input ready);
  modport sink   (input valid, channel_value, frame_pending, failsafe_clear,
                  frame_loaded, output ready);
endinterface

FILE: hw/rtl/rcsfd_ctrl.sv
// ----------------------------------------------------------------------------
// rcsfd_ctrl: sequencer of the serial frame decoder
// Steps each request through byte store or frame check, channel decode,
// channel pick and hand-off to the result register.
// ----------------------------------------------------------------------------
module rcsfd_ctrl
  import rcsfd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_op,
  output logic ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = SEL_HDR;
    ready      = 1'b0;
    case (state)
      ST_IDLE: begin
        ready = 1'b1;
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = req_op ? ST_CHECK : ST_BYTE;
        end
      end
      ST_BYTE: begin
        cmd.byte_write = 1'b1;
        state_next     = ST_FINISH;
      end
      ST_CHECK: begin
        // fetch the header byte only when a frame waits
        if (sts.complete) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = SEL_HDR;
          state_next = ST_HDR;
        end else begin
          state_next = ST_PICK;
        end
      end
      ST_HDR: begin
        cmd.chk_hdr = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = SEL_TAIL;
        state_next  = ST_TAIL;
      end
      ST_TAIL: begin
        cmd.chk_tail = 1'b1;
        if (sts.frame_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = SEL_HI;
          state_next = ST_HI;
        end else begin
          state_next = ST_PICK;
        end
      end
      ST_HI: begin
        cmd.dec_hi = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_LO;
        state_next = ST_LO;
      end
      ST_LO: begin
        cmd.dec_lo = 1'b1;
        if (sts.k_last) begin
          state_next = ST_PICK;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = SEL_NEXT_HI;
          state_next = ST_HI;
        end
      end
      ST_PICK: begin
        cmd.pick   = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the result register can take the result
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Decode runs only on a frame that passed both checks
  a_decode_after_check: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAIL && sts.frame_ok) |=> (state == ST_HI && cmd.dec_hi))
    else $error("decode did not start after a good frame check");

  // The controller is ready again after each hand-off to the result register
  a_push_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> ready)
    else $error("controller not ready after hand-off");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |=> !ready)
    else $error("request taken while an item is in flight");

endmodule

FILE: hw/rtl/rcsfd_dp.sv
// ----------------------------------------------------------------------------
// rcsfd_dp: datapath of the serial frame decoder
// Frame buffer memory, write position and gap timer, channel store with
// decode arithmetic, configuration registers and the result register.
// ----------------------------------------------------------------------------
module rcsfd_dp
  import rcsfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // request payload
  input  logic [7:0]            req_rx_byte,
  input  logic [31:0]           req_arrival_time_us,
  input  logic [7:0]            req_channel,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // control
  input  cmd_t                  cmd,
  output sts_t                  sts,
  // result register
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_channel_value,
  output logic                  out_frame_pending,
  output logic                  out_failsafe_clear,
  output logic                  out_frame_loaded
);

  // Configuration registers
  logic [15:0] gap_limit_us;
  logic [15:0] mid_value;

  // Captured request
  logic [7:0]  it_byte;
  logic [31:0] it_time;
  logic [7:0]  it_channel;

  // Frame state
  logic [7:0]          fbuf [FRAME_LEN];
  logic [7:0]          rd_data;
  logic [POS_W-1:0]    rd_addr;
  logic [POS_W-1:0]    wpos;
  logic [POS_W-1:0]    wpos_eff;
  logic [31:0]         last_arrival;
  logic [31:0]         gap;
  logic                complete;
  logic                hdr_ok;
  logic                frame_ok;
  logic [CH_IDX_W-1:0] k;
  logic [POS_W-1:0]    k2;
  logic [7:0]          hi_byte;
  logic [15:0]         raw;
  logic [18:0]         raw_x5;
  logic [15:0]         dec_val;
  logic [15:0]         chan_store [CHANNEL_COUNT];

  // Result fields before the result register
  logic [15:0] res_value;
  logic        res_pulse;
  logic        res_loaded;

  // Configuration writes; other indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit_us <= GAP_LIMIT_RST;
      mid_value    <= MID_VALUE_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_GAP_LIMIT) begin
        gap_limit_us <= cfg_data;
      end
      if (cfg_index == CFG_MID_VALUE) begin
        mid_value <= cfg_data;
      end
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_byte    <= req_rx_byte;
      it_time    <= req_arrival_time_us;
      it_channel <= req_channel;
    end
  end

  // Gap test: restart the frame on a long pause, clamp at the last position
  always_comb begin
    gap      = it_time - last_arrival;
    wpos_eff = wpos;
    if (gap > {16'd0, gap_limit_us}) begin
      wpos_eff = '0;
    end
    if (wpos_eff > LAST_POS) begin
      wpos_eff = LAST_POS;
    end
  end

  // Read address for the frame checks and the decode walk
  assign k2 = {1'b0, k, 1'b0};

  always_comb begin
    case (cmd.rd_sel)
      SEL_HDR:     rd_addr = HDR_POS;
      SEL_TAIL:    rd_addr = TAIL_POS;
      SEL_HI:      rd_addr = HI_BASE + k2;
      SEL_LO:      rd_addr = LO_BASE + k2;
      SEL_NEXT_HI: rd_addr = NXT_BASE + k2;
      default:     rd_addr = HDR_POS;
    endcase
  end

  // Frame buffer memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.byte_write) begin
      fbuf[wpos_eff] <= it_byte;
    end
    if (cmd.rd_en) begin
      rd_data <= fbuf[rd_addr];
    end
  end

  // Write position, arrival time and complete flag
  always_ff @(posedge clk) begin
    if (rst) begin
      wpos         <= '0;
      last_arrival <= '0;
      complete     <= 1'b0;
    end else begin
      if (cmd.byte_write) begin
        last_arrival <= it_time;
        if (wpos_eff == LAST_POS) begin
          complete <= 1'b1;
          wpos     <= wpos_eff;
        end else begin
          wpos <= wpos_eff + 5'd1;
        end
      end else if (cmd.chk_tail) begin
        complete <= 1'b0;
      end
    end
  end

  // Frame checks: header byte, then zero tail byte
  assign frame_ok = hdr_ok && (rd_data == 8'd0);

  always_ff @(posedge clk) begin
    if (cmd.chk_hdr) begin
      hdr_ok <= (rd_data == HEADER_BYTE);
    end
    if (cmd.dec_hi) begin
      hi_byte <= rd_data;
    end
  end

  // Channel word decode: floor(5 * raw / 32) - 375
  assign raw     = {hi_byte, rd_data};
  assign raw_x5  = {3'd0, raw} + {1'b0, raw, 2'b00};
  assign dec_val = {2'd0, raw_x5[18:5]} - OFFSET_SUB;

  // Channel index walk
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.load_item) begin
      k <= '0;
    end else if (cmd.dec_lo) begin
      k <= k + 3'd1;
    end
  end

  // Channel store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        chan_store[i] <= '0;
      end
    end else if (cmd.dec_lo) begin
      chan_store[k] <= dec_val;
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (rst) begin
      res_value  <= '0;
      res_pulse  <= 1'b0;
      res_loaded <= 1'b0;
    end else if (cmd.load_item) begin
      res_value  <= '0;
      res_pulse  <= 1'b0;
      res_loaded <= 1'b0;
    end else begin
      if (cmd.byte_write && wpos_eff == LAST_POS) begin
        res_pulse <= 1'b1;
      end
      if (cmd.dec_lo) begin
        res_loaded <= 1'b1;
      end
      if (cmd.pick) begin
        if (it_channel >= 8'(CHANNEL_COUNT)) begin
          res_value <= mid_value;
        end else begin
          res_value <= chan_store[chan_map(it_channel[CH_IDX_W-1:0])];
        end
      end
    end
  end

  // Result register: load on push, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_channel_value  <= res_value;
      out_frame_pending  <= complete;
      out_failsafe_clear <= res_pulse;
      out_frame_loaded   <= res_loaded;
    end
  end

  // Status to the controller
  assign sts.complete = complete;
  assign sts.frame_ok = frame_ok;
  assign sts.k_last   = (k == 3'(CHANNEL_COUNT - 1));
  assign sts.out_free = !out_valid || out_ready;

  // A push never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // A decoded frame has its complete flag cleared
  a_loaded_clears: assert property (@(posedge clk) disable iff (rst)
    res_loaded |-> !complete)
    else $error("frame loaded while still marked complete");

  // Reads stay inside the frame
  a_rd_in_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (rd_addr < POS_W'(FRAME_LEN)))
    else $error("frame buffer read beyond the frame");

  // Position never passes the last byte
  a_wpos_range: assert property (@(posedge clk) disable iff (rst)
    cmd.byte_write |=> (wpos <= LAST_POS))
    else $error("write position beyond the frame");

endmodule

FILE: hw/rtl/rc_serial_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder_unit: receiver byte framer and channel decoder
// Collects timestamped receiver bytes into a 21-byte frame and serves channel
// reads, decoding a pending valid frame into eight channel values first.
//
//   channel   dir  handshake      payload
//   req       in   valid/ready    op, rx_byte, arrival_time_us, channel
//   rsp       out  valid/ready    channel_value, frame_pending,
//                                 failsafe_clear, frame_loaded
//   cfg       in   cfg_we only    cfg_index, cfg_data
//
// Steps: a byte is stored, then pushed to the result register; a read with no
// pending frame is checked, then picks its channel; a read of a pending frame
// also checks header and tail and decodes channels byte by byte through the
// single buffer read port. A new request is taken the cycle after the push.
// Reset: synchronous; gap limit 5000, mid value 1500, channels zero.
// Stalls: the result register holds a result until taken while the next
// request is accepted; that request waits at its end for the register.
// ----------------------------------------------------------------------------
module rc_serial_frame_decoder_unit
  import rcsfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  rcsfd_req_if.sink             req,
  rcsfd_rsp_if.source           rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  rcsfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .ready     (req.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath
  rcsfd_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .req_rx_byte         (req.rx_byte),
    .req_arrival_time_us (req.arrival_time_us),
    .req_channel         (req.channel),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (rsp.valid),
    .out_ready           (rsp.ready),
    .out_channel_value   (rsp.channel_value),
    .out_frame_pending   (rsp.frame_pending),
    .out_failsafe_clear  (rsp.failsafe_clear),
    .out_frame_loaded    (rsp.frame_loaded)
  );

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the receiver serial frame decoder
// Sends timestamped bytes and channel reads over the request channel, runs its
// own model of the framer and channel decoder on every accepted request, and
// checks each result in order. A short directed table comes first, then
// random frames, reads and noise over several gap limit and mid value
// settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import rcsfd_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'd255;
  localparam int   SETTLE_CYCLES = 30;
  localparam int   HOLD_CYCLES   = 400;
  localparam logic [2:0] PHYS_CH [CHANNEL_COUNT] =
    '{3'd1, 3'd2, 3'd3, 3'd0, 3'd4, 3'd5, 3'd6, 3'd7};

  typedef struct packed {
    logic [15:0] value;
    logic        pending;
    logic        fs_clear;
    logic        loaded;
  } rc_result_t;

  typedef enum {ROW_BYTE, ROW_READ, ROW_FRAME} row_kind_t;

  // data is the byte (or the header of a frame); t is its time (or frame start)
  typedef struct {
    row_kind_t   kind;
    logic [7:0]  data;
    logic [7:0]  tail;
    logic [31:0] t;
    logic [31:0] step;
    logic [7:0]  ch;
    logic [15:0] fill;
    bit          typed;
    rc_result_t  want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rcsfd_req_if req_ch();
  rcsfd_rsp_if rsp_ch();

  rc_serial_frame_decoder_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model state of the framer and channel store
  logic [7:0]  frm_bytes [FRAME_LEN] = '{default: 8'h00};
  logic [4:0]  wr_pos = '0;
  logic [31:0] last_t = '0;
  bit          frm_ready = 1'b0;
  logic [15:0] chan_val [CHANNEL_COUNT] = '{default: 16'h0000};
  logic [15:0] gap_lim = GAP_LIMIT_RST;
  logic [15:0] mid_val = MID_VALUE_RST;

  rc_result_t  decoded_q [$];
  logic [31:0] t_now = '0;
  int          burst_left = 0;
  bit          hold_rsp = 1'b0;
  int          sent_items = 0;
  int          n_bytes = 0;
  int          n_reads = 0;
  int          n_frames = 0;
  int          n_loads = 0;
  int          n_results = 0;
  int          n_err = 0;
  dir_row_t    dir_tab [$];

  // Advance the model by one request and return the result it owes
  function automatic rc_result_t frame_decode_step(input logic op, input logic [7:0] rx,
                                                   input logic [31:0] t,
                                                   input logic [7:0] ch);
    rc_result_t  r;
    logic [31:0] gap;
    logic [15:0] raw;
    logic [31:0] scaled;
    r = '0;
    if (op == OP_BYTE) begin
      gap    = t - last_t;
      last_t = t;
      if (gap > {16'd0, gap_lim}) wr_pos = '0;
      frm_bytes[wr_pos] = rx;
      if (wr_pos == LAST_POS) begin
        frm_ready  = 1'b1;
        r.fs_clear = 1'b1;
      end else begin
        wr_pos = wr_pos + 5'd1;
      end
    end else begin
      if (frm_ready) begin
        if (frm_bytes[HDR_POS] == HEADER_BYTE && frm_bytes[TAIL_POS] == 8'h00) begin
          for (int k = 0; k < CHANNEL_COUNT; k++) begin
            raw         = {frm_bytes[HI_BASE + 2*k], frm_bytes[LO_BASE + 2*k]};
            scaled      = ({16'd0, raw} * 32'd5) >> 5;
            chan_val[k] = scaled[15:0] - OFFSET_SUB;
          end
          r.loaded = 1'b1;
        end
        frm_ready = 1'b0;
      end
      r.value = (ch >= CHANNEL_COUNT) ? mid_val : chan_val[PHYS_CH[ch[2:0]]];
    end
    r.pending = frm_ready;
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // Offer one request in bursts with random gaps, then record what it owes
  task automatic send_req(input logic op, input logic [7:0] rx, input logic [31:0] t,
                          input logic [7:0] ch, input bit typed, input rc_result_t want);
    int         idle;
    rc_result_t r;
    idle = 0;
    if (burst_left == 0) begin
      idle       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    if (idle > 0) begin
      req_ch.valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    req_ch.valid           = 1'b1;
    req_ch.op              = op;
    req_ch.rx_byte         = rx;
    req_ch.arrival_time_us = t;
    req_ch.channel         = ch;
    do @(posedge clk); while (!req_ch.ready);
    r = frame_decode_step(op, rx, t, ch);
    decoded_q.push_back(typed ? want : r);
    sent_items++;
    if (op == OP_BYTE) n_bytes++;
    else n_reads++;
  endtask

  task automatic send_byte(input logic [7:0] rx, input logic [31:0] t);
    t_now = t;
    send_req(OP_BYTE, rx, t, 8'($urandom()), 1'b0, '0);
  endtask

  task automatic send_read(input logic [7:0] ch);
    send_req(OP_READ, 8'($urandom()), $urandom(), ch, 1'b0, '0);
  endtask

  // Send a frame of len bytes, one every step microseconds
  task automatic send_frame(input logic [7:0] hdr, input logic [7:0] tail,
                            input logic [15:0] fill, input bit rnd,
                            input logic [31:0] t0, input logic [31:0] step, input int len);
    logic [7:0]  b;
    logic [31:0] t;
    t = t0;
    for (int p = 0; p < len; p++) begin
      if (p == HDR_POS) b = hdr;
      else if (p == TAIL_POS) b = tail;
      else if (rnd) b = 8'($urandom());
      else b = (p % 2 == 1) ? fill[15:8] : fill[7:0];
      send_byte(b, t);
      t = t + step;
    end
  endtask

  // Write a register; the model takes the new value as the write is driven
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    if (idx == CFG_GAP_LIMIT) gap_lim = d;
    else if (idx == CFG_MID_VALUE) mid_val = d;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drop valid, wait for every owed result, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_channel();
    return ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom());
  endfunction

  // Mostly well-formed frames with random content, plus reads, noise and broken frames
  task automatic run_random(input int n);
    int          stop;
    int          r;
    int          nrd;
    int          len;
    logic [31:0] step;
    logic [31:0] t0;
    logic [7:0]  hdr;
    logic [7:0]  tail;
    stop = sent_items + n;
    while (sent_items < stop) begin
      r   = $urandom_range(0, 99);
      nrd = 0;
      if (r < 55) begin
        hdr  = ($urandom_range(0, 9) != 0) ? HEADER_BYTE : 8'($urandom());
        tail = ($urandom_range(0, 9) != 0) ? 8'h00 : 8'($urandom());
        step = ($urandom_range(0, 19) != 0) ? $urandom_range(0, gap_lim)
                                            : gap_lim + 1 + $urandom_range(0, 1000);
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20)
                                           : FRAME_LEN + $urandom_range(0, 2);
        t0   = t_now + gap_lim + 1 + $urandom_range(0, 5000);
        send_frame(hdr, tail, 16'h0000, 1'b1, t0, step, len);
        nrd = $urandom_range(0, 3);
      end else if (r < 80) begin
        nrd = $urandom_range(1, 4);
      end else begin
        send_byte(8'($urandom()), $urandom_range(0, 1) ? $urandom()
                                                       : t_now + $urandom_range(0, gap_lim));
      end
      repeat (nrd) send_read(pick_channel());
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    rc_result_t got;
    rc_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.channel_value, rsp_ch.frame_pending, rsp_ch.failsafe_clear,
              rsp_ch.frame_loaded};
      n_results++;
      if (got.fs_clear) n_frames++;
      if (got.loaded) n_loads++;
      if (decoded_q.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("ERROR: result with nothing owed: value=%h pend=%b fs=%b load=%b",
                   got.value, got.pending, got.fs_clear, got.loaded);
      end else begin
        want = decoded_q.pop_front();
        if (got.value !== want.value || got.pending !== want.pending ||
            got.fs_clear !== want.fs_clear || got.loaded !== want.loaded) begin
          n_err++;
          if (n_err <= 10)
            $display({"ERROR: result %0d: exp value=%h pend=%b fs=%b load=%b, ",
                      "got value=%h pend=%b fs=%b load=%b"},
                     n_results, want.value, want.pending, want.fs_clear, want.loaded,
                     got.value, got.pending, got.fs_clear, got.loaded);
        end
      end
    end
  end

  // Result side: stall on a changing pattern, with one long hold-off on request
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        hold_rsp     = 1'b0;
        rsp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(8, 40);
      end
      left--;
      case (mode)
        0: begin
          rsp_ch.ready = 1'b1;
        end
        1: begin
          rsp_ch.ready = 1'($urandom_range(0, 1));
        end
        default: begin
          rsp_ch.ready = ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Stimulus
  initial begin
    req_ch.valid           = 1'b0;
    req_ch.op              = OP_BYTE;
    req_ch.rx_byte         = '0;
    req_ch.arrival_time_us = '0;
    req_ch.channel         = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst       = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: reads after reset, timestamp wrap, frame extremes,
    // bytes while a frame is pending, and frames with a bad header or tail
    dir_tab.push_back('{ROW_READ,  8'h00, 8'h00, 32'h0, 32'h0, 8'd0,   16'h0,
                        1'b1, '{16'd0, 1'b0, 1'b0, 1'b0}});
    dir_tab.push_back('{ROW_READ,  8'h00, 8'h00, 32'h0, 32'h0, 8'd255, 16'h0,
                        1'b1, '{16'd1500, 1'b0, 1'b0, 1'b0}});
    dir_tab.push_back('{ROW_READ,  8'h00, 8'h00, 32'h0, 32'h0, 8'd8,   16'h0,
                        1'b1, '{16'd1500, 1'b0, 1'b0, 1'b0}});
    dir_tab.push_back('{ROW_BYTE,  8'hFF, 8'h00, 32'hFFFF_FFFF, 32'h0, 8'd0, 16'h0,
                        1'b1, '{16'd0, 1'b0, 1'b0, 1'b0}});
    dir_tab.push_back('{ROW_BYTE,  8'h00, 8'h00, 32'h0000_0004, 32'h0, 8'd0, 16'h0,
                        1'b1, '{16'd0, 1'b0, 1'b0, 1'b0}});
    dir_tab.push_back('{ROW_FRAME, HEADER_BYTE, 8'h00, 32'h0001_0000, 32'd5000, 8'd0,
                        16'hFFFF, 1'b0, '0});
    dir_tab.push_back('{ROW_BYTE,  8'h55, 8'h00, 32'h0002_86A1, 32'h0, 8'd0, 16'h0,
                        1'b0, '0});
    dir_tab.push_back('{ROW_READ,  8'h00, 8'h00, 32'h0, 32'h0, 8'd3,   16'h0, 1'b0, '0});
    dir_tab.push_back('{ROW_READ,  8'h00, 8'h00, 32'h0, 32'h0, 8'd7,   16'h0, 1'b0, '0});
    dir_tab.push_back('{ROW_READ,  8'h00, 8'h00, 32'h0, 32'h0, 8'd200, 16'h0, 1'b0, '0});
    dir_tab.push_back('{ROW_FRAME, HEADER_BYTE, 8'h00, 32'h0020_0000, 32'd0, 8'd0,
                        16'h0000, 1'b0, '0});
    dir_tab.push_back('{ROW_BYTE,  HEADER_BYTE, 8'h00, 32'h0028_0000, 32'h0, 8'd0, 16'h0,
                        1'b0, '0});
    dir_tab.push_back('{ROW_READ,  8'h00, 8'h00, 32'h0, 32'h0, 8'd1,   16'h0, 1'b0, '0});
    dir_tab.push_back('{ROW_FRAME, 8'h57, 8'h00, 32'h0030_0000, 32'd1, 8'd0,
                        16'h1234, 1'b0, '0});
    dir_tab.push_back('{ROW_READ,  8'h00, 8'h00, 32'h0, 32'h0, 8'd0,   16'h0, 1'b0, '0});
    dir_tab.push_back('{ROW_FRAME, HEADER_BYTE, 8'h01, 32'h0040_0000, 32'd2, 8'd0,
                        16'h8000, 1'b0, '0});
    dir_tab.push_back('{ROW_READ,  8'h00, 8'h00, 32'h0, 32'h0, 8'd4,   16'h0, 1'b0, '0});
    dir_tab.push_back('{ROW_READ,  8'h00, 8'h00, 32'h0, 32'h0, 8'd5,   16'h0, 1'b0, '0});

    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_BYTE: begin
          t_now = dir_tab[i].t;
          send_req(OP_BYTE, dir_tab[i].data, dir_tab[i].t, 8'($urandom()),
                   dir_tab[i].typed, dir_tab[i].want);
        end
        ROW_READ: begin
          send_req(OP_READ, 8'($urandom()), $urandom(), dir_tab[i].ch,
                   dir_tab[i].typed, dir_tab[i].want);
        end
        default: begin
          send_frame(dir_tab[i].data, dir_tab[i].tail, dir_tab[i].fill, 1'b0,
                     dir_tab[i].t, dir_tab[i].step, FRAME_LEN);
        end
      endcase
    end

    // Reset settings
    run_random(50);
    settle();

    // Lowest settings; hold the result side off early in this phase
    write_reg(CFG_GAP_LIMIT, 16'd0);
    write_reg(CFG_MID_VALUE, 16'd0);
    hold_rsp = 1'b1;
    run_random(80);
    settle();

    // Highest settings, plus writes to unused indexes that must be dropped
    write_reg(CFG_GAP_LIMIT, 16'hFFFF);
    write_reg(CFG_MID_VALUE, 16'hFFFF);
    write_reg(CFG_IDX_SPARE, 16'h0001);
    write_reg(CFG_IDX_TOP,   16'hA5A5);
    run_random(80);
    settle();

    // Random settings
    write_reg(CFG_GAP_LIMIT, 16'($urandom_range(1, 20000)));
    write_reg(CFG_MID_VALUE, 16'($urandom()));
    run_random(110);
    settle();

    $display("Sent %0d bytes and %0d channel reads over four register settings",
             n_bytes, n_reads);
    $display("Saw %0d frame completions and %0d frame decodes; %0d mismatches",
             n_frames, n_loads, n_err);
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/rcsfd_pkg.sv
hw/rtl/rcsfd_if.sv
hw/rtl/rcsfd_ctrl.sv
hw/rtl/rcsfd_dp.sv
hw/rtl/rc_serial_frame_decoder_unit.sv
test/tb_top.sv
